// ===== rtl/core/lvps_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the latching valve pulse sequencer.
// No dependencies; used by every other file of the block except lvps_res_if.
package lvps_pkg;

	localparam int unsigned TickW   = 16;
	localparam int unsigned FuncW   = 3;
	localparam int unsigned CfgIdxW = 1;

	localparam logic [TickW-1:0] WaitTicksRst  = 16'd100;
	localparam logic [TickW-1:0] PulseTicksRst = 16'd75;

	localparam logic [CfgIdxW-1:0] CFG_WAIT_TICKS  = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_PULSE_TICKS = 1'b1;

	typedef enum logic [FuncW-1:0] {
		FN_TICK       = 3'd0,
		FN_OPEN       = 3'd1,
		FN_CLOSE      = 3'd2,
		FN_OPEN_CLOSE = 3'd3,
		FN_RETRY      = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_PULSE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		MODE_CLOSE      = 2'd0,
		MODE_OPEN       = 2'd1,
		MODE_OPEN_CLOSE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [TickW-1:0] wait_ticks;
		logic [TickW-1:0] pulse_ticks;
	} cfg_t;

	typedef struct packed {
		logic coil_one_on;
		logic coil_two_on;
		logic finish_sent;
		logic notice_pending;
		logic busy_res;
	} res_t;

endpackage

// ===== rtl/core/lvps_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the valve sequencer: valid/ready with func and queue_ready.
// Depends on lvps_pkg for field widths.
interface lvps_req_if;
	logic                        valid;
	logic                        ready;
	logic [lvps_pkg::FuncW-1:0] func;
	logic                        queue_ready;

	modport source (output valid, func, queue_ready, input ready);
	modport sink (input valid, func, queue_ready, output ready);
endinterface

// ===== rtl/core/lvps_res_if.sv =====
`timescale 1ns / 1ps
// Result channel of the valve sequencer: valid/ready with coil and notice status.
// No dependencies.
interface lvps_res_if;
	logic valid;
	logic ready;
	logic coil_one_on;
	logic coil_two_on;
	logic finish_sent;
	logic notice_pending;
	logic busy_res;

	modport source (output valid, coil_one_on, coil_two_on, finish_sent, notice_pending,
		busy_res, input ready);
	modport sink (input valid, coil_one_on, coil_two_on, finish_sent, notice_pending,
		busy_res, output ready);
endinterface

// ===== rtl/core/latching_valve_pulse_sequencer_top.sv =====
`timescale 1ns / 1ps
// Latching valve pulse sequencer: two-coil valve driver with timed wait and pulse.
// Depends on lvps_pkg, lvps_req_if, lvps_res_if, lvps_cfg_regs, lvps_seq, lvps_out_stage.
//
// Usage:
//   req carries one request per handshake: func (tick, open, close, open-then-close,
//   retry notice, others ignored) and queue_ready. res returns exactly one result per
//   request: coil drive levels, finish notice delivered, notice pending and busy.
//   cfg_we/cfg_idx/cfg_wdata write wait_ticks (index 0) and pulse_ticks (index 1);
//   a new value is used from the next phase start. Write only while idle.
//   The result of a request is registered and is valid the cycle after it is accepted.
//   Throughput: one request per cycle while not stalled; the state update is a single pass through
//   the sequencer logic into its state and the result register.
//   Stall: req.ready stays high while the result register is empty or being taken
//   in the same cycle; while the receiver holds res.ready low with a result waiting,
//   req.ready drops and state holds.
//   Reset: both coils off, idle, no notice pending, wait 100 and pulse 75 ticks,
//   no result valid.
module latching_valve_pulse_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lvps_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [lvps_pkg::TickW-1:0]   cfg_wdata,
	lvps_req_if.sink                      req,
	lvps_res_if.source                    res
);

	lvps_pkg::cfg_t cfg;
	lvps_pkg::res_t res_d;
	logic           space;
	logic           acc;

	assign req.ready = space;
	assign acc       = req.valid && space;

	lvps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lvps_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.func        (req.func),
		.queue_ready (req.queue_ready),
		.cfg         (cfg),
		.res_d       (res_d)
	);

	lvps_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (acc),
		.res_d  (res_d),
		.space  (space),
		.res    (res)
	);

endmodule

// ===== rtl/core/lvps_cfg_regs.sv =====
`timescale 1ns / 1ps
// Wait and pulse length registers behind the plain write port.
// Depends on lvps_pkg.
module lvps_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lvps_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [lvps_pkg::TickW-1:0]   cfg_wdata,
	output lvps_pkg::cfg_t                cfg
);

	lvps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_ticks  <= lvps_pkg::WaitTicksRst;
			cfg_q.pulse_ticks <= lvps_pkg::PulseTicksRst;
		end else if (cfg_we) begin
			case (cfg_idx)
				lvps_pkg::CFG_WAIT_TICKS:  cfg_q.wait_ticks  <= cfg_wdata;
				lvps_pkg::CFG_PULSE_TICKS: cfg_q.pulse_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/lvps_seq.sv =====
`timescale 1ns / 1ps
// Valve sequencer state and its single-pass next-state logic per request.
// Depends on lvps_pkg.
module lvps_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [lvps_pkg::FuncW-1:0] func,
	input  logic                        queue_ready,
	input  lvps_pkg::cfg_t              cfg,
	output lvps_pkg::res_t              res_d
);

	lvps_pkg::phase_t             phase_q, phase_d;
	lvps_pkg::mode_t              mode_q, mode_d;
	logic [lvps_pkg::TickW-1:0]  ticks_q, ticks_d;
	logic                         coil_one_q, coil_one_d;
	logic                         coil_two_q, coil_two_d;
	logic                         pending_q, pending_d;
	logic                         sent;

	always_comb begin
		phase_d    = phase_q;
		mode_d     = mode_q;
		ticks_d    = ticks_q;
		coil_one_d = coil_one_q;
		coil_two_d = coil_two_q;
		pending_d  = pending_q;
		sent       = 1'b0;
		case (func)
			lvps_pkg::FN_TICK: begin
				if (phase_q == lvps_pkg::PH_WAIT || phase_q == lvps_pkg::PH_PULSE) begin
					if (ticks_q > 16'd1) begin
						ticks_d = ticks_q - 16'd1;
					end else if (phase_q == lvps_pkg::PH_WAIT) begin
						if (mode_q == lvps_pkg::MODE_OPEN || mode_q == lvps_pkg::MODE_OPEN_CLOSE)
							coil_two_d = 1'b1;
						else if (mode_q == lvps_pkg::MODE_CLOSE)
							coil_one_d = 1'b1;
						phase_d = lvps_pkg::PH_PULSE;
						ticks_d = cfg.pulse_ticks;
					end else begin
						coil_one_d = 1'b0;
						coil_two_d = 1'b0;
						if (mode_q == lvps_pkg::MODE_OPEN_CLOSE) begin
							mode_d  = lvps_pkg::MODE_CLOSE;
							phase_d = lvps_pkg::PH_WAIT;
							ticks_d = cfg.wait_ticks;
						end else begin
							phase_d = lvps_pkg::PH_IDLE;
							ticks_d = '0;
							if (queue_ready) begin
								sent      = 1'b1;
								pending_d = 1'b0;
							end else begin
								pending_d = 1'b1;
							end
						end
					end
				end
			end
			lvps_pkg::FN_OPEN, lvps_pkg::FN_CLOSE, lvps_pkg::FN_OPEN_CLOSE: begin
				case (func)
					lvps_pkg::FN_OPEN:  mode_d = lvps_pkg::MODE_OPEN;
					lvps_pkg::FN_CLOSE: mode_d = lvps_pkg::MODE_CLOSE;
					default:            mode_d = lvps_pkg::MODE_OPEN_CLOSE;
				endcase
				coil_one_d = 1'b0;
				coil_two_d = 1'b0;
				phase_d    = lvps_pkg::PH_WAIT;
				ticks_d    = cfg.wait_ticks;
			end
			lvps_pkg::FN_RETRY: begin
				if (pending_q && queue_ready) begin
					pending_d = 1'b0;
					sent      = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lvps_pkg::PH_IDLE;
			mode_q     <= lvps_pkg::MODE_CLOSE;
			ticks_q    <= '0;
			coil_one_q <= 1'b0;
			coil_two_q <= 1'b0;
			pending_q  <= 1'b0;
		end else if (acc) begin
			phase_q    <= phase_d;
			mode_q     <= mode_d;
			ticks_q    <= ticks_d;
			coil_one_q <= coil_one_d;
			coil_two_q <= coil_two_d;
			pending_q  <= pending_d;
		end
	end

	assign res_d.coil_one_on    = coil_one_d;
	assign res_d.coil_two_on    = coil_two_d;
	assign res_d.finish_sent    = sent;
	assign res_d.notice_pending = pending_d;
	assign res_d.busy_res       = (phase_d == lvps_pkg::PH_WAIT) ||
		(phase_d == lvps_pkg::PH_PULSE);

`ifndef NO_ASSERTIONS
	a_coils_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(coil_one_q && coil_two_q))
		else $error("both valve coils driven");

	a_coil_only_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(coil_one_q || coil_two_q) |-> (phase_q == lvps_pkg::PH_PULSE))
		else $error("coil driven outside pulse phase");

	a_idle_counter_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lvps_pkg::PH_IDLE) |-> (ticks_q == '0))
		else $error("tick counter not clear while idle");

	a_request_starts_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (func == lvps_pkg::FN_OPEN || func == lvps_pkg::FN_CLOSE ||
		func == lvps_pkg::FN_OPEN_CLOSE)) |=>
		(phase_q == lvps_pkg::PH_WAIT && !coil_one_q && !coil_two_q))
		else $error("valve request did not start a wait phase");
`endif

endmodule

// ===== rtl/core/lvps_out_stage.sv =====
`timescale 1ns / 1ps
// Result register between the sequencer and the result channel.
// Depends on lvps_pkg and lvps_res_if.
module lvps_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  lvps_pkg::res_t res_d,
	output logic           space,
	lvps_res_if.source     res
);

	logic           valid_q;
	lvps_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign space              = !valid_q || res.ready;
	assign res.valid          = valid_q;
	assign res.coil_one_on    = res_q.coil_one_on;
	assign res.coil_two_on    = res_q.coil_two_on;
	assign res.finish_sent    = res_q.finish_sent;
	assign res.notice_pending = res_q.notice_pending;
	assign res.busy_res       = res_q.busy_res;

`ifndef NO_ASSERTIONS
	a_sent_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.finish_sent) |-> !res_q.notice_pending)
		else $error("notice delivered but still pending");

	a_load_only_with_space: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("result loaded over an untaken result");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not presented");
`endif

endmodule
